// ----- design/tbfsvf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the three-band formant filter.
`timescale 1ns / 1ps

package tbfsvf_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int NUM_CHANNELS_DEF = 2;
	localparam int NUM_BANDS = 3;

	localparam int STATE_W = 32;
	localparam int SUM_W = 34;
	localparam int MA_W = 36;
	localparam int MB_W = 19;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W = 56;

	localparam int COEF_W = 18;
	localparam int DAMP_W = 17;
	localparam int MIX_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [MIX_W-1:0] MIX_FULL = MIX_W'(65536);
	localparam logic [MIX_W-1:0] WET_GAIN = MIX_W'(117965);
	localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(36045);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF0 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COEF1 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COEF2 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_MIX = CFG_IDX_W'(5);

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic channel_in;
		sample_t sample_in;
	} in_item_t;

	typedef struct packed {
		logic channel_out;
		sample_t sample_out;
	} out_item_t;

	localparam acc_t STATE_MAX = (acc_t'(1) <<< (STATE_W - 1)) - acc_t'(1);
	localparam acc_t STATE_MIN = -(acc_t'(1) <<< (STATE_W - 1));
	localparam acc_t SMP_MAX = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
	localparam acc_t SMP_MIN = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

	// Round to nearest with ties toward plus infinity, then drop 16 fraction bits.
	function automatic acc_t rnd16(acc_t v);
		return (v + acc_t'(32768)) >>> 16;
	endfunction

	function automatic state_t sat32(acc_t v);
		acc_t c;
		c = v;
		if (v > STATE_MAX) c = STATE_MAX;
		else if (v < STATE_MIN) c = STATE_MIN;
		return c[STATE_W-1:0];
	endfunction

	function automatic sample_t sat_sample(acc_t v);
		acc_t c;
		c = v;
		if (v > SMP_MAX) c = SMP_MAX;
		else if (v < SMP_MIN) c = SMP_MIN;
		return c[SAMPLE_BITS-1:0];
	endfunction

endpackage

// ----- design/tbfsvf_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module tbfsvf_mul (
	input  logic                                  clk,
	input  logic signed [tbfsvf_pkg::MA_W-1:0]    a,
	input  logic signed [tbfsvf_pkg::MB_W-1:0]    b,
	output logic signed [tbfsvf_pkg::PROD_W-1:0]  p
);
	import tbfsvf_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

// ----- design/three_band_formant_svf_filter.sv -----
// Top level of the three-band formant filter: config registers, sequencer and state stores.
`timescale 1ns / 1ps

// Three-band formant filter built from Chamberlin state-variable bandpass sections.
// Input items (channel, sample) arrive on src_valid/src_stall; results leave on
// dst_valid/dst_stall, one result per item, in order.
// All multiplies run through one registered multiplier under a small sequencer:
// each band takes six steps (state read, three multiplies, three updates), and
// the wet sum and dry/wet blend take four more, plus a done step that hands the
// result to the output register. A bypassed item (filter disabled or channel
// without state) skips the band and blend steps and goes straight to the done
// step. src_stall is high while an item is in work, so one item is processed at
// a time.
// The output register holds a finished result while the receiver stalls, and the
// next item is accepted meanwhile; that item waits at the end of its work until
// the register frees up.
// Reset clears all filter state, the config registers to their defaults and the
// output valid. Configuration is written through cfg_write/cfg_index/cfg_data,
// one register per cycle, and should only be changed while the block is idle.

module three_band_formant_svf_filter #(
	parameter int NUM_CHANNELS = tbfsvf_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   src_valid,
	output logic                                   src_stall,
	input  tbfsvf_pkg::in_item_t                   src_item,
	output logic                                   dst_valid,
	input  logic                                   dst_stall,
	output tbfsvf_pkg::out_item_t                  dst_item,
	input  logic                                   cfg_write,
	input  logic [tbfsvf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tbfsvf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tbfsvf_pkg::*;

	localparam int NST = NUM_CHANNELS * NUM_BANDS;
	localparam int KW = (NST > 1) ? $clog2(NST) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_M1, ST_LPU, ST_HPU, ST_M3, ST_BPU,
		ST_WM, ST_WR, ST_XM, ST_YM, ST_DONE
	} seq_state_t;

	seq_state_t state_q;
	logic [1:0] band_q;

	logic en_q;
	logic [COEF_W-1:0] coef_q [NUM_BANDS];
	logic [DAMP_W-1:0] damp_q;
	logic [MIX_W-1:0] mix_q;

	state_t lp_st_q [NST];
	state_t bp_st_q [NST];

	logic ch_q;
	sample_t x_q;
	sample_t y_q;
	state_t lp_q, bp_q, hp_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [MA_W-1:0] wet_q;
	acc_t acc_q;

	logic dst_valid_q;
	out_item_t dst_item_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;

	logic accept;
	logic filter_go;
	logic [KW-1:0] kidx;
	logic [MIX_W-1:0] mix_eff;
	logic [COEF_W-1:0] coef_sel;
	acc_t rnd_p;
	state_t lp_new, hp_new, bp_new;
	sample_t y_new;
	logic out_free;

	assign accept = src_valid && !src_stall;
	assign src_stall = (state_q != ST_IDLE);
	assign filter_go = en_q && (int'(src_item.channel_in) < NUM_CHANNELS);
	assign kidx = KW'(int'(ch_q) * NUM_BANDS + int'(band_q));
	assign mix_eff = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
	assign coef_sel = coef_q[band_q];
	assign rnd_p = rnd16(acc_t'(prod));
	assign lp_new = sat32(acc_t'(lp_q) + rnd_p);
	assign hp_new = sat32(acc_t'(x_q) - acc_t'(lp_q) - rnd_p);
	assign bp_new = sat32(acc_t'(bp_q) + rnd_p);
	assign y_new = sat_sample(rnd16(acc_q + acc_t'(prod)));
	assign out_free = !dst_valid_q || !dst_stall;

	// Operand selection for the shared multiplier; the product is registered and appears in the following cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = MA_W'(bp_q);
				mul_b = MB_W'({1'b0, coef_sel});
			end
			ST_LPU: begin
				mul_a = MA_W'(bp_q);
				mul_b = MB_W'({1'b0, damp_q});
			end
			ST_M3: begin
				mul_a = MA_W'(hp_q);
				mul_b = MB_W'({1'b0, coef_sel});
			end
			ST_WM: begin
				mul_a = MA_W'(sum_q);
				mul_b = MB_W'({1'b0, WET_GAIN});
			end
			ST_WR: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'({1'b0, MIX_FULL - mix_eff});
			end
			ST_XM: begin
				mul_a = wet_q;
				mul_b = MB_W'({1'b0, mix_eff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tbfsvf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			for (int i = 0; i < NUM_BANDS; i++) coef_q[i] <= '0;
			damp_q <= DAMP_RESET;
			mix_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_COEF0: coef_q[0] <= cfg_data[COEF_W-1:0];
				REG_COEF1: coef_q[1] <= cfg_data[COEF_W-1:0];
				REG_COEF2: coef_q[2] <= cfg_data[COEF_W-1:0];
				REG_DAMPING: damp_q <= cfg_data[DAMP_W-1:0];
				REG_MIX: mix_q <= cfg_data[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, filter state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q <= '0;
			dst_valid_q <= 1'b0;
			for (int i = 0; i < NST; i++) begin
				lp_st_q[i] <= '0;
				bp_st_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) dst_valid_q <= 1'b1;
			else if (!dst_stall) dst_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					band_q <= '0;
					if (accept) state_q <= filter_go ? ST_RD : ST_DONE;
				end
				ST_RD: state_q <= ST_M1;
				ST_M1: state_q <= ST_LPU;
				ST_LPU: state_q <= ST_HPU;
				ST_HPU: state_q <= ST_M3;
				ST_M3: state_q <= ST_BPU;
				ST_BPU: begin
					lp_st_q[kidx] <= lp_q;
					bp_st_q[kidx] <= bp_new;
					if (band_q == 2'(NUM_BANDS - 1)) begin
						state_q <= ST_WM;
					end else begin
						band_q <= band_q + 2'd1;
						state_q <= ST_RD;
					end
				end
				ST_WM: state_q <= ST_WR;
				ST_WR: state_q <= ST_XM;
				ST_XM: state_q <= ST_YM;
				ST_YM: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_q <= src_item.channel_in;
					x_q <= src_item.sample_in;
					y_q <= src_item.sample_in;
					sum_q <= '0;
				end
			end
			ST_RD: begin
				lp_q <= lp_st_q[kidx];
				bp_q <= bp_st_q[kidx];
			end
			ST_LPU: lp_q <= lp_new;
			ST_HPU: hp_q <= hp_new;
			ST_BPU: sum_q <= sum_q + SUM_W'(bp_new);
			ST_WR: wet_q <= rnd_p[MA_W-1:0];
			ST_XM: acc_q <= acc_t'(prod);
			ST_YM: y_q <= y_new;
			ST_DONE: begin
				if (out_free) begin
					dst_item_q.channel_out <= ch_q;
					dst_item_q.sample_out <= y_q;
				end
			end
			default: ;
		endcase
	end

	assign dst_valid = dst_valid_q;
	assign dst_item = dst_item_q;

endmodule

// ----- dv/three_band_formant_svf_filter_tb.sv -----
// Self-checking testbench for the three-band formant filter: directed rows, then random phases.
`timescale 1ns / 1ps

module three_band_formant_svf_filter_tb;
	import tbfsvf_pkg::*;

	typedef logic signed [63:0] wide_t;
	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		in_item_t item;
		logic typed;
		sample_t want;
	} stim_row_t;

	// Indexes past the last register; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = CFG_IDX_W'(7);

	localparam wide_t UNITY_Q16 = 64'sd65536;
	localparam wide_t WET_SCALE = 64'sd117965;
	localparam wide_t ST_HI = 64'sd2147483647;
	localparam wide_t ST_LO = -64'sd2147483648;
	localparam wide_t OUT_HI = 64'sd8388607;
	localparam wide_t OUT_LO = -64'sd8388608;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_ITEMS = 147;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	in_item_t src_item;
	logic dst_valid;
	logic dst_stall;
	out_item_t dst_item;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Local copy of the register file and the filter state.
	logic filt_on;
	logic [COEF_W-1:0] tune [NUM_BANDS];
	logic [DAMP_W-1:0] damp;
	logic [MIX_W-1:0] mix_amt;
	state_t lp_mem [NUM_CHANNELS_DEF][NUM_BANDS];
	state_t bp_mem [NUM_CHANNELS_DEF][NUM_BANDS];

	out_item_t pending_outputs [$];
	stim_row_t stim_rows [$];
	wide_t walk_level;

	int src_idle_pct;
	int dst_idle_pct;
	bit hold_req;
	int hold_left;
	int n_errors;
	int n_items;
	int n_checked;
	int n_filtered;
	int n_clipped;

	three_band_formant_svf_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item(dst_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d outputs still outstanding.", pending_outputs.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Floor of (v + 0.5) in Q16, i.e. round half up, dropping the 16 fraction bits.
	function automatic wide_t round_q16(wide_t v);
		wide_t t;
		t = v + 64'sd32768;
		return {{16{t[63]}}, t[63:16]};
	endfunction

	function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Filters a sample through the three SVF sections, updating local state, when enabled.
	function automatic out_item_t formant_response(in_item_t it);
		wide_t x, y, f, q, lp, bp, hp, sum, wet, wmix;
		int ch, b;
		out_item_t r;
		x = {{(64-SAMPLE_BITS){it.sample_in[SAMPLE_BITS-1]}}, it.sample_in};
		y = x;
		ch = it.channel_in;
		if (filt_on && ch < NUM_CHANNELS_DEF) begin
			q = {47'b0, damp};
			sum = 0;
			for (b = 0; b < NUM_BANDS; b++) begin
				f = {46'b0, tune[b]};
				lp = lp_mem[ch][b];
				bp = bp_mem[ch][b];
				lp = clip(lp + round_q16(f * bp), ST_LO, ST_HI);
				hp = clip(x - lp - round_q16(q * bp), ST_LO, ST_HI);
				bp = clip(bp + round_q16(f * hp), ST_LO, ST_HI);
				lp_mem[ch][b] = lp[STATE_W-1:0];
				bp_mem[ch][b] = bp[STATE_W-1:0];
				sum += bp;
			end
			wet = round_q16(sum * WET_SCALE);
			wmix = (mix_amt > MIX_FULL) ? UNITY_Q16 : {47'b0, mix_amt};
			y = round_q16(x * (UNITY_Q16 - wmix) + wet * wmix);
			if (y > OUT_HI || y < OUT_LO) n_clipped++;
			y = clip(y, OUT_LO, OUT_HI);
			n_filtered++;
		end
		r.channel_out = it.channel_in;
		r.sample_out = y[SAMPLE_BITS-1:0];
		return r;
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_item(logic ch, sample_t smp, logic typed, sample_t want);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.item.channel_in = ch;
		r.item.sample_in = smp;
		r.typed = typed;
		r.want = want;
		stim_rows.push_back(r);
	endfunction

	function automatic sample_t pick_sample();
		int jump;
		case ($urandom_range(15))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			3, 4, 5: begin
				jump = int'($urandom_range(8191)) - 4096;
				return sample_t'(jump);
			end
			6, 7, 8, 9, 10: begin
				// Random walk keeps the signal band-limited, closer to real audio.
				jump = int'($urandom_range(131072)) - 65536;
				walk_level = clip(walk_level + jump, OUT_LO, OUT_HI);
				return walk_level[SAMPLE_BITS-1:0];
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_coef();
		case ($urandom_range(7))
			0: return '0;
			1: return CFG_DATA_W'(131072);
			2: return CFG_DATA_W'($urandom_range(262143));
			default: return CFG_DATA_W'($urandom_range(131072, 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_damp();
		logic [DAMP_W-1:0] v;
		case ($urandom_range(5))
			0: v = DAMP_RESET;
			1: v = DAMP_W'(124518);
			2: v = DAMP_W'($urandom_range(131071));
			default: v = DAMP_W'($urandom_range(124518, 36045));
		endcase
		return {1'($urandom_range(1)), v};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_mix();
		logic [MIX_W-1:0] v;
		case ($urandom_range(5))
			0: v = '0;
			1: v = MIX_FULL;
			2: v = MIX_W'($urandom_range(131071, 65537));
			default: v = MIX_W'($urandom_range(65536));
		endcase
		return {1'($urandom_range(1)), v};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ENABLE: filt_on = data[0];
			REG_COEF0: tune[0] = data[COEF_W-1:0];
			REG_COEF1: tune[1] = data[COEF_W-1:0];
			REG_COEF2: tune[2] = data[COEF_W-1:0];
			REG_DAMPING: damp = data[DAMP_W-1:0];
			REG_MIX: mix_amt = data[MIX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic offer_sample(input in_item_t it, input logic typed, input sample_t want);
		out_item_t r;
		cfg_write <= 1'b0;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		r = formant_response(it);
		if (typed) r.sample_out = want;
		pending_outputs.push_back(r);
		n_items++;
	endtask

	task automatic drain_outputs();
		src_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic check_output(input out_item_t got);
		out_item_t want;
		if (pending_outputs.size() == 0) begin
			$display("%0t: MISMATCH output with nothing pending, expected none, got ch %0d sample %0d",
				$time, got.channel_out, $signed(got.sample_out));
			n_errors++;
			return;
		end
		want = pending_outputs.pop_front();
		n_checked++;
		if (got.channel_out !== want.channel_out) begin
			$display("%0t: MISMATCH channel_out expected %0d, got %0d",
				$time, want.channel_out, got.channel_out);
			n_errors++;
		end
		if (got.sample_out !== want.sample_out) begin
			$display("%0t: MISMATCH sample_out expected %0d, got %0d",
				$time, $signed(want.sample_out), $signed(got.sample_out));
			n_errors++;
		end
	endtask

	// Output side: checks every accepted item and drives the stall pattern.
	initial begin
		dst_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dst_valid && !dst_stall) check_output(dst_item);
			if (hold_left > 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(99) < dst_idle_pct);
			end
		end
	end

	initial begin
		int ph, i, b, c;
		stim_row_t row;
		in_item_t it;
		arst_n <= 1'b0;
		src_valid <= 1'b0;
		src_item <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		filt_on = 1'b0;
		damp = DAMP_RESET;
		mix_amt = '0;
		walk_level = 0;
		hold_req = 1'b0;
		hold_left = 0;
		src_idle_pct = 10;
		dst_idle_pct = 68;
		for (b = 0; b < NUM_BANDS; b++) begin
			tune[b] = '0;
			for (c = 0; c < NUM_CHANNELS_DEF; c++) begin
				lp_mem[c][b] = '0;
				bp_mem[c][b] = '0;
			end
		end

		// Out of reset the filter is off, so every sample comes back untouched.
		add_item(1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF);
		add_item(1'b1, 24'h800000, 1'b1, 24'h800000);
		add_item(1'b0, 24'h000000, 1'b1, 24'h000000);
		add_item(1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
		add_cfg(REG_SPARE6, 18'h3FFFF);
		add_cfg(REG_SPARE7, 18'h3FFFF);
		add_cfg(REG_ENABLE, 18'h3FFFE);
		add_item(1'b0, 24'h123456, 1'b1, 24'h123456);
		// Enabled with no wet share: the state moves but the output stays dry.
		add_cfg(REG_ENABLE, 18'h00001);
		add_cfg(REG_COEF0, 18'h20000);
		add_cfg(REG_COEF1, 18'h20000);
		add_cfg(REG_COEF2, 18'h20000);
		add_item(1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF);
		add_item(1'b1, 24'h800000, 1'b1, 24'h800000);
		add_item(1'b0, 24'h400000, 1'b1, 24'h400000);
		add_cfg(REG_MIX, 18'h10000);
		add_cfg(REG_COEF0, 18'h00CCD);
		add_cfg(REG_COEF1, 18'h03000);
		add_cfg(REG_COEF2, 18'h09000);
		add_cfg(REG_DAMPING, 18'd36045);
		add_item(1'b0, 24'h7FFFFF, 1'b0, '0);
		add_item(1'b0, 24'h7FFFFF, 1'b0, '0);
		add_item(1'b1, 24'h000000, 1'b0, '0);
		add_item(1'b0, 24'h800000, 1'b0, '0);
		add_item(1'b1, 24'h100000, 1'b0, '0);
		// Mix above full scale, coefficients and damping outside the usable range.
		add_cfg(REG_MIX, 18'h1FFFF);
		add_cfg(REG_COEF0, 18'h3FFFF);
		add_cfg(REG_COEF1, 18'h3FFFF);
		add_cfg(REG_COEF2, 18'h3FFFF);
		add_cfg(REG_DAMPING, 18'h00000);
		add_item(1'b0, 24'h7FFFFF, 1'b0, '0);
		add_item(1'b0, 24'h800000, 1'b0, '0);
		add_item(1'b1, 24'h7FFFFF, 1'b0, '0);
		add_item(1'b1, 24'h7FFFFF, 1'b0, '0);
		add_cfg(REG_DAMPING, 18'd124518);
		add_cfg(REG_MIX, 18'h08000);
		add_cfg(REG_COEF0, 18'h20000);
		add_cfg(REG_COEF1, 18'h00000);
		add_cfg(REG_COEF2, 18'h01000);
		add_item(1'b0, 24'h800000, 1'b0, '0);
		add_item(1'b1, 24'h2AAAAA, 1'b0, '0);
		add_item(1'b0, 24'h555555, 1'b0, '0);
		add_cfg(REG_DAMPING, 18'h1FFFF);
		add_item(1'b1, 24'h800000, 1'b0, '0);
		add_item(1'b0, 24'h000001, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CFG) begin
				drain_outputs();
				write_reg(row.idx, row.data);
			end else begin
				offer_sample(row.item, row.typed, row.want);
			end
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			drain_outputs();
			if (ph < 2) begin
				src_idle_pct = 10;
				dst_idle_pct = 68;
			end else if (ph < 4) begin
				src_idle_pct = 68;
				dst_idle_pct = 10;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			// One phase runs with the filter off to confirm the state is held.
			write_reg(REG_ENABLE, {17'($urandom), ph != RAND_PHASES - 2});
			write_reg(REG_COEF0, pick_coef());
			write_reg(REG_COEF1, pick_coef());
			write_reg(REG_COEF2, pick_coef());
			write_reg(REG_DAMPING, pick_damp());
			write_reg(REG_MIX, pick_mix());
			if (ph == 2) write_reg(REG_SPARE7, CFG_DATA_W'($urandom));
			if (ph == 1) hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 4 && i == PHASE_ITEMS / 2) drain_outputs();
				it.channel_in = 1'($urandom_range(1));
				it.sample_in = pick_sample();
				offer_sample(it, 1'b0, '0);
			end
		end

		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			$display("%0t: MISMATCH %0d expected outputs never arrived",
				$time, pending_outputs.size());
			n_errors++;
		end
		$display("Drove %0d samples: a directed table and %0d random register settings.",
			n_items, RAND_PHASES);
		$display("Checked %0d outputs; %0d were filtered and %0d hit the sample limits.",
			n_checked, n_filtered, n_clipped);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/tbfsvf_pkg.sv
design/tbfsvf_mul.sv
design/three_band_formant_svf_filter.sv
dv/three_band_formant_svf_filter_tb.sv
